### sv/ntil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntil_pkg: shared types and constants for the timestamp index lookup
// Table geometry, operation and status codes, payload structs, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ntil_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int STAMP_W     = 63;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [STAMP_W-1:0]        stamp_ns;
    logic signed [DATA_W-1:0]  query_rel_ns;
  } ntil_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] floor_index;
    logic [ADDR_W-1:0] nearest_index;
    logic [CNT_W-1:0]  entry_total;
  } ntil_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHK0,
    S_SRCH,
    S_NEAR_RD,
    S_NEAR_A,
    S_NEAR_B,
    S_NEAR_C,
    S_DONE
  } ntil_state_t;

  // Read address select for the table
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_MID_NEXT,
    RD_BEST,
    RD_BEST1
  } ntil_rd_sel_t;

  typedef struct packed {
    logic         capture;
    logic         clear_tbl;
    logic         append;
    logic         query_empty;
    logic         noop;
    logic         srch_init;
    logic         srch_step;
    logic         load_dlo;
    logic         load_dhi;
    logic         finish_query;
    ntil_rd_sel_t rd_sel;
  } ntil_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            at_head;
    logic            cont;
    logic            has_next;
  } ntil_stat_t;

endpackage

### sv/nearest_timestamp_index_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_index_lookup_top: timestamp table with floor/nearest search
// Loads frame stamps relative to the first one and answers query times with
// the floor and nearest table indices by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the transaction is taken on a clock edge
//   where start is high and busy is low. busy stays high until the result.
//   The result appears on result for exactly one cycle with done high; the
//   receiver must take it then, it cannot be held off.
//   Clear, append and unused codes go from decode straight to done, as does
//   a query on an empty table. A query runs CHK0, the search steps (at most
//   floor(log2(entries)) + 1, so 11 for a 1024-entry table), NEAR_RD and,
//   unless floor is the last entry, NEAR_A to NEAR_C for the nearest compare.
//   One table read per cycle on the single RAM read port sets the search
//   pace; busy drops in the cycle after done, so the next start follows then.
//   Reset (synchronous, rst high) empties the table and clears the origin;
//   table contents are not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_timestamp_index_lookup_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ntil_pkg::ntil_req_t request,
  output logic                busy,
  output logic                done,
  output ntil_pkg::ntil_rsp_t result
);
  import ntil_pkg::*;

  ntil_cmd_t  cmd;
  ntil_stat_t stat;

  ntil_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ntil_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

### sv/ntil_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntil_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ntil_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ntil_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntil_datapath: table storage, search registers and result register
// Holds the origin stamp, the entry count and the offset table, and runs the
// binary search and nearest-neighbor compare under controller commands.
// ----------------------------------------------------------------------------
module ntil_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ntil_pkg::ntil_req_t request,
  input  ntil_pkg::ntil_cmd_t cmd,
  output ntil_pkg::ntil_stat_t stat,
  output ntil_pkg::ntil_rsp_t result
);
  import ntil_pkg::*;

  ntil_req_t          req;
  logic [DATA_W-1:0]  origin;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi1;
  logic [ADDR_W-1:0]  mid;
  logic [ADDR_W-1:0]  best;
  logic [DATA_W-1:0]  dlo;
  logic [DATA_W-1:0]  dhi;

  logic [ADDR_W-1:0]  raddr;
  logic [DATA_W-1:0]  rdata;
  logic               we;
  logic [DATA_W-1:0]  wdata;

  logic               le;
  logic               at_head;
  logic [CNT_W-1:0]   lo_next;
  logic [CNT_W-1:0]   hi1_next;
  logic [ADDR_W-1:0]  best_next;
  logic [CNT_W:0]     mid_sum;
  logic [ADDR_W-1:0]  mid_next;
  logic [CNT_W:0]     init_sum;
  logic [ADDR_W-1:0]  mid_init;
  logic               full;
  logic               has_next;
  logic [CNT_W-1:0]   count_inc;

  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
    if ($signed(b) <= $signed(a)) begin
      return a - b;
    end
    return b - a;
  endfunction

  // Search step: compare the entry just read against the query
  always_comb begin
    le        = $signed(rdata) <= $signed(req.query_rel_ns);
    at_head   = $signed(req.query_rel_ns) <= $signed(rdata);
    lo_next   = le ? ({1'b0, mid} + CNT_W'(1)) : lo;
    hi1_next  = le ? hi1 : {1'b0, mid};
    best_next = le ? mid : best;
    mid_sum   = {1'b0, lo_next} + {1'b0, hi1_next} - (CNT_W + 1)'(1);
    mid_next  = mid_sum[ADDR_W:1];
    init_sum  = {1'b0, count} - (CNT_W + 1)'(1);
    mid_init  = init_sum[ADDR_W:1];
    full      = count >= CNT_W'(TABLE_DEPTH);
    has_next  = ({1'b0, best} + CNT_W'(1)) < count;
    count_inc = count + CNT_W'(1);
  end

  // Select the table read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:     raddr = '0;
      RD_MID_NEXT: raddr = cmd.srch_init ? mid_init : mid_next;
      RD_BEST:     raddr = best;
      RD_BEST1:    raddr = best + ADDR_W'(1);
      default:     raddr = '0;
    endcase
  end

  // Append write: offset from the origin, zero for the first entry
  always_comb begin
    we    = cmd.append && !full;
    wdata = (count == '0) ? '0 : ({1'b0, req.stamp_ns} - origin);
  end

  ntil_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      origin <= '0;
    end else if (cmd.clear_tbl) begin
      count  <= '0;
      origin <= '0;
    end else if (we) begin
      count <= count_inc;
      if (count == '0) begin
        origin <= {1'b0, req.stamp_ns};
      end
    end
  end

  // Request latch and search registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    if (cmd.srch_init) begin
      lo   <= '0;
      hi1  <= count;
      best <= '0;
      mid  <= mid_init;
    end else if (cmd.srch_step) begin
      lo   <= lo_next;
      hi1  <= hi1_next;
      best <= best_next;
      mid  <= mid_next;
    end
    if (cmd.load_dlo) begin
      dlo <= abs_diff(rdata, req.query_rel_ns);
    end
    if (cmd.load_dhi) begin
      dhi <= abs_diff(rdata, req.query_rel_ns);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    priority if (cmd.clear_tbl) begin
      result <= ntil_rsp_t'{STAT_OK, '0, '0, '0};
    end else if (cmd.append) begin
      result <= full ? ntil_rsp_t'{STAT_FULL, '0, '0, count} :
                       ntil_rsp_t'{STAT_OK, '0, '0, count_inc};
    end else if (cmd.query_empty) begin
      result <= ntil_rsp_t'{STAT_EMPTY, '0, '0, '0};
    end else if (cmd.noop) begin
      result <= ntil_rsp_t'{STAT_OK, '0, '0, count};
    end else if (cmd.finish_query) begin
      result.status        <= STAT_OK;
      result.floor_index   <= best;
      result.nearest_index <= (has_next && (dhi < dlo)) ? best + ADDR_W'(1) : best;
      result.entry_total   <= count;
    end
  end

  assign stat = '{op: req.operation, cnt_zero: (count == '0), at_head: at_head,
                  cont: (lo_next < hi1_next), has_next: has_next};

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_step_interval: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_step |-> (lo < hi1) && ({1'b0, mid} < count))
    else $error("search step outside the held entries");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.append && full) |=> $stable(count))
    else $error("append on full table changed the count");
`endif

endmodule

### sv/ntil_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntil_ctrl: transaction sequencer for the timestamp index lookup
// Decodes each operation and steps the datapath through the binary search
// and the nearest-neighbor compare.
// ----------------------------------------------------------------------------
module ntil_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ntil_pkg::ntil_stat_t stat,
  output ntil_pkg::ntil_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import ntil_pkg::*;

  ntil_state_t state;
  ntil_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((stat.op == OP_QUERY) && !stat.cnt_zero) begin
          state_next = S_CHK0;
        end else begin
          state_next = S_DONE;
        end
      end
      // a query at or before entry 0 skips the search with floor 0
      S_CHK0:    state_next = stat.at_head ? S_NEAR_RD : S_SRCH;
      S_SRCH:    state_next = stat.cont ? S_SRCH : S_NEAR_RD;
      S_NEAR_RD: state_next = stat.has_next ? S_NEAR_A : S_DONE;
      S_NEAR_A:  state_next = S_NEAR_B;
      S_NEAR_B:  state_next = S_NEAR_C;
      S_NEAR_C:  state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_CLEAR:  cmd.clear_tbl = 1'b1;
          OP_APPEND: cmd.append    = 1'b1;
          OP_QUERY: begin
            cmd.query_empty = stat.cnt_zero;
            cmd.rd_sel      = RD_ZERO;
          end
          default:   cmd.noop      = 1'b1;
        endcase
      end
      S_CHK0: begin
        cmd.srch_init = 1'b1;
        cmd.rd_sel    = RD_MID_NEXT;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        cmd.rd_sel    = RD_MID_NEXT;
      end
      S_NEAR_RD: begin
        cmd.rd_sel       = RD_BEST;
        cmd.finish_query = !stat.has_next;
      end
      S_NEAR_A: begin
        cmd.rd_sel   = RD_BEST1;
        cmd.load_dlo = 1'b1;
      end
      S_NEAR_B:  cmd.load_dhi     = 1'b1;
      S_NEAR_C:  cmd.finish_query = 1'b1;
      S_DONE:    done             = 1'b1;
      default:   busy             = 1'b1;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("busy held after result strobe");

  a_one_result_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_tbl, cmd.append, cmd.query_empty, cmd.noop, cmd.finish_query}))
    else $error("more than one result load in a cycle");
`endif

endmodule

### verif/nearest_timestamp_index_lookup_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_index_lookup_top_tb: self-checking bench for the lookup
// Builds stamp tables with clear and append commands, then queries them. A
// local shadow of the table predicts the floor and nearest indices, status
// and entry count for every accepted transaction. Each done strobe is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module nearest_timestamp_index_lookup_top_tb;
  import ntil_pkg::*;

  localparam int QUIET_TAIL  = 150;   // last commands sent back to back
  localparam int MIN_TOTAL   = 1200;  // least command count before generation stops
  localparam int MAX_REPORTS = 10;

  typedef struct {
    ntil_req_t req;
    bit        drain;   // hold this command until every result is back
  } lookup_cmd_t;

  logic      clk;
  logic      rst     = 1'b1;
  logic      start   = 1'b0;
  ntil_req_t request = '0;
  logic      busy;
  logic      done;
  ntil_rsp_t result;

  lookup_cmd_t cmd_backlog[$];
  ntil_rsp_t   answer_q[$];
  int          mismatch_count = 0;

  // Shadow of the block's table
  logic signed [DATA_W-1:0] offset_tbl [TABLE_DEPTH];
  logic        [DATA_W-1:0] origin_stamp = '0;
  int unsigned              held_count   = 0;

  // Generator's view of the table, used to aim queries
  logic signed [DATA_W-1:0] gen_offs[$];
  logic        [DATA_W-1:0] gen_origin;

  int unsigned idle_left = 0;
  bit          slot_free;

  nearest_timestamp_index_lookup_top uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random stamp over the full field width
  function automatic logic [STAMP_W-1:0] rand_stamp();
    return STAMP_W'({$urandom, $urandom});
  endfunction

  // Distance between two signed times as an unsigned magnitude
  function automatic logic [DATA_W-1:0] span_ns(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the shadow table by one command and return its answer
  function automatic ntil_rsp_t predict_lookup(input ntil_req_t req);
    ntil_rsp_t                rsp;
    logic signed [DATA_W-1:0] q;
    int                       lo, hi, mid;
    int unsigned              fl, nr;
    rsp = '0;
    q   = $signed(req.query_rel_ns);
    fl  = 0;
    nr  = 0;
    case (req.operation)
      OP_CLEAR: begin
        held_count   = 0;
        origin_stamp = '0;
      end
      OP_APPEND: begin
        if (held_count >= TABLE_DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          if (held_count == 0) origin_stamp = {1'b0, req.stamp_ns};
          offset_tbl[held_count] = {1'b0, req.stamp_ns} - origin_stamp;
          held_count++;
        end
      end
      OP_QUERY: begin
        if (held_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          // floor stays 0 unless the query lies past entry 0
          if (q > offset_tbl[0]) begin
            lo = 0;
            hi = held_count - 1;
            while (lo <= hi) begin
              mid = lo + (hi - lo) / 2;
              if (offset_tbl[mid] <= q) begin
                fl = mid;
                lo = mid + 1;
              end else begin
                hi = mid - 1;
              end
            end
          end
          nr = fl;
          // ties go to floor
          if (fl + 1 < held_count) begin
            if (span_ns(offset_tbl[fl + 1], q) < span_ns(offset_tbl[fl], q)) nr = fl + 1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.floor_index   = fl[ADDR_W-1:0];
    rsp.nearest_index = nr[ADDR_W-1:0];
    rsp.entry_total   = held_count[CNT_W-1:0];
    return rsp;
  endfunction

  // Queue one command and track the table it builds
  task automatic queue_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                            input logic [DATA_W-1:0] q, input bit drain);
    lookup_cmd_t c;
    c.req.operation    = op;
    c.req.stamp_ns     = stamp;
    c.req.query_rel_ns = q;
    c.drain            = drain;
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (op == OP_CLEAR) begin
      gen_offs.delete();
    end else if (op == OP_APPEND && gen_offs.size() < TABLE_DEPTH) begin
      if (gen_offs.size() == 0) gen_origin = {1'b0, stamp};
      gen_offs.insert(gen_offs.size(), {1'b0, stamp} - gen_origin);
    end
  endtask

  // Append n non-decreasing stamps with one random step scale
  task automatic build_table(input int n);
    logic [STAMP_W-1:0] stamp;
    int                 k;
    int                 scale;
    scale = $urandom_range(0, 2);
    stamp = ($urandom_range(0, 4) == 0) ? '0 :
            rand_stamp() & {2'b00, {61{1'b1}}};
    for (k = 0; k < n; k++) begin
      queue_item(OP_APPEND, stamp, {$urandom, $urandom}, 1'b0);
      case (scale)
        0:       stamp += STAMP_W'($urandom_range(0, 3));
        1:       stamp += STAMP_W'($urandom_range(0, 1_000_000));
        default: stamp += STAMP_W'({$urandom_range(0, 255), $urandom});
      endcase
    end
  endtask

  // Pick a query time near, on, between or outside the held entries
  function automatic logic [DATA_W-1:0] pick_query();
    int                       i;
    logic signed [DATA_W-1:0] a, b;
    if (gen_offs.size() == 0) return {$urandom, $urandom};
    i = $urandom_range(0, gen_offs.size() - 1);
    a = gen_offs[i];
    b = (i + 1 < gen_offs.size()) ? gen_offs[i + 1] : a + 64'sd2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return a;
      4:          return ($urandom_range(0, 1) != 0) ? a + 1 : a - 1;
      5:          return a + ((b - a) >>> 1);
      6:          return gen_offs[0] - DATA_W'($urandom_range(1, 1000));
      7:          return gen_offs[$] + DATA_W'($urandom_range(1, 1000));
      8:          return {$urandom, $urandom};
      default:    return ($urandom_range(0, 1) != 0) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Driver: offer commands, predict on accept, insert idle bursts
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      request   <= '0;
      idle_left = 0;
    end else begin
      slot_free = !start;
      if (start && !busy) begin
        answer_q.insert(answer_q.size(), predict_lookup(request));
        slot_free = 1'b1;
        if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 9);
      end
      if (slot_free) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain && answer_q.size() > 0)) begin
          request <= cmd_backlog[0].req;
          start   <= 1'b1;
          void'(cmd_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each strobed result against the oldest prediction
  always @(posedge clk) begin
    ntil_rsp_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        flag_mismatch("unexpected result entry_total", '0, DATA_W'(result.entry_total));
      end else begin
        want = answer_q.pop_front();
        if (result.status !== want.status)
          flag_mismatch("status", DATA_W'(want.status), DATA_W'(result.status));
        if (result.floor_index !== want.floor_index)
          flag_mismatch("floor_index", DATA_W'(want.floor_index),
                        DATA_W'(result.floor_index));
        if (result.nearest_index !== want.nearest_index)
          flag_mismatch("nearest_index", DATA_W'(want.nearest_index),
                        DATA_W'(result.nearest_index));
        if (result.entry_total !== want.entry_total)
          flag_mismatch("entry_total", DATA_W'(want.entry_total),
                        DATA_W'(result.entry_total));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [DATA_W-1:0] q_min, q_max;
    int                kind;
    bit                first_seq;
    bit                fill_done;
    q_min     = {1'b1, 63'd0};
    q_max     = {1'b0, {63{1'b1}}};
    first_seq = 1'b1;
    fill_done = 1'b0;

    // Directed: empty table, unused code, extreme stamps and queries
    queue_item(OP_QUERY, '0, '0, 1'b0);
    queue_item(OP_RSVD, {STAMP_W{1'b1}}, {DATA_W{1'b1}}, 1'b0);
    queue_item(OP_CLEAR, '0, '0, 1'b0);
    queue_item(OP_APPEND, {STAMP_W{1'b1}}, '0, 1'b0);
    queue_item(OP_QUERY, '0, q_min, 1'b0);
    queue_item(OP_QUERY, '0, q_max, 1'b0);
    // decreasing stamp: offset goes far negative
    queue_item(OP_APPEND, '0, '0, 1'b0);
    queue_item(OP_QUERY, '0, q_max, 1'b0);
    queue_item(OP_QUERY, '0, q_min, 1'b0);
    queue_item(OP_CLEAR, '0, '0, 1'b0);
    // offsets 0, 10, 20, 20, 40 with a duplicate stamp
    queue_item(OP_APPEND, 63'd1000, '0, 1'b0);
    queue_item(OP_APPEND, 63'd1010, '0, 1'b0);
    queue_item(OP_APPEND, 63'd1020, '0, 1'b0);
    queue_item(OP_APPEND, 63'd1020, '0, 1'b0);
    queue_item(OP_APPEND, 63'd1040, '0, 1'b0);
    // ties, near misses, exact hits, past last and before first
    queue_item(OP_QUERY, '0, 64'sd5, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd6, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd20, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd30, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd31, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd40, 1'b0);
    queue_item(OP_QUERY, '0, 64'sd1000, 1'b0);
    queue_item(OP_QUERY, '0, -64'sd5, 1'b0);
    queue_item(OP_RSVD, '0, '0, 1'b0);

    // Random: mostly built tables with aimed queries, some noise
    while (cmd_backlog.size() < MIN_TOTAL || !fill_done) begin
      kind = $urandom_range(0, 9);
      if (!fill_done && cmd_backlog.size() > 120) begin
        // fill to capacity, then overflow appends and queries
        queue_item(OP_CLEAR, rand_stamp(), {$urandom, $urandom}, 1'b1);
        build_table(TABLE_DEPTH);
        repeat (3) queue_item(OP_APPEND, rand_stamp(), {$urandom, $urandom}, 1'b0);
        repeat (12) queue_item(OP_QUERY, rand_stamp(), pick_query(), 1'b0);
        fill_done = 1'b1;
      end else if (kind <= 6) begin
        queue_item(OP_CLEAR, rand_stamp(), {$urandom, $urandom},
                   first_seq || $urandom_range(0, 3) == 0);
        first_seq = 1'b0;
        build_table(($urandom_range(0, 7) == 0) ? $urandom_range(33, 300) :
                    $urandom_range(1, 32));
        repeat ($urandom_range(5, 25))
          queue_item(OP_QUERY, rand_stamp(), pick_query(), 1'b0);
      end else if (kind == 7) begin
        repeat ($urandom_range(3, 12))
          queue_item(OP_W'($urandom_range(0, 3)), rand_stamp(), {$urandom, $urandom}, 1'b0);
      end else if (kind == 8) begin
        // append unordered stamps onto whatever is held
        repeat ($urandom_range(3, 12)) begin
          if ($urandom_range(0, 1) != 0)
            queue_item(OP_APPEND, rand_stamp(), {$urandom, $urandom}, 1'b0);
          else
            queue_item(OP_QUERY, rand_stamp(), pick_query(), 1'b0);
        end
      end else begin
        queue_item(OP_CLEAR, rand_stamp(), {$urandom, $urandom}, 1'b0);
        queue_item(OP_QUERY, rand_stamp(), {$urandom, $urandom}, 1'b0);
        queue_item(OP_RSVD, rand_stamp(), {$urandom, $urandom}, 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain the backlog, then the outstanding results
    while (cmd_backlog.size() > 0 || start) @(posedge clk);
    while (answer_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### nearest_timestamp_index_lookup_top.f
sv/ntil_pkg.sv
sv/ntil_ram.sv
sv/ntil_datapath.sv
sv/ntil_ctrl.sv
sv/nearest_timestamp_index_lookup_top.sv
verif/nearest_timestamp_index_lookup_top_tb.sv
